// File: rtl/core/lzssd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LZSS bitstream decoder.
// No dependencies; imported by the decoder top level and the checker.
package lzssd_pkg;

  localparam int BYTE_BITS = 8;
  localparam int LIT_BITS  = 8;
  localparam int BL_W      = $clog2(BYTE_BITS + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BITS,
    S_COPY,
    S_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LIT,
    PH_POS,
    PH_LEN
  } phase_t;

endpackage

// File: rtl/core/lzssd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// Read during write to the same address returns the old contents.
module lzssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/lzss_bitstream_decoder.sv
`timescale 1ns / 1ps
// LZSS bitstream decoder top level: bit parser, match copier, output staging.
// Depends on lzssd_pkg and lzssd_ram (history window).
//
// Usage:
//   Input words (in_tdata, one compressed byte) are read MSB first, one bit
//   per cycle while no match is being copied and the output path has room.
//   A flag bit of 1 precedes an 8-bit literal; a flag bit of 0 precedes a
//   window position and a length, and the match copies length+2 bytes out
//   of the history window. Position zero ends the stream: one notice word
//   (data zero, tuser high) comes out; later words are accepted and dropped.
//   Output words carry the decoded byte; tlast marks the final output word
//   caused by one input word.
// Timing:
//   An input word is accepted, its 8 bits are parsed and it is flushed; a
//   match completed inside it adds one window read per copied byte.
// Reset:
//   After reset the window is cleared one entry per cycle, all
//   2**POSITION_BITS entries (4096 by default), with in_tready low.
// Stall:
//   A stalled receiver holds the output word; decoding halts when the output
//   register and the one-word staging register are both full.
module lzss_bitstream_decoder #(
  parameter int POSITION_BITS = 12,
  parameter int LENGTH_BITS   = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // last_of_run
  output logic       out_tuser   // [0] end_of_stream
);

  import lzssd_pkg::*;

  localparam int DEPTH = 1 << POSITION_BITS;
  localparam int PB_W  = (POSITION_BITS > LIT_BITS) ? POSITION_BITS : LIT_BITS;
  localparam int PC_W  = $clog2(PB_W + 1);
  localparam int CNT_W = LENGTH_BITS + 1;

  state_t                   state_r, state_nxt;
  phase_t                   phase_r, phase_nxt;
  logic [PB_W-1:0]          pend_r, pend_nxt;
  logic [PC_W-1:0]          pcnt_r, pcnt_nxt;
  logic [POSITION_BITS-1:0] mpos_r, mpos_nxt;
  logic                     done_r, done_nxt;
  logic [POSITION_BITS-1:0] wp_r, wp_nxt;
  logic [POSITION_BITS-1:0] clr_r, clr_nxt;
  logic [BL_W-1:0]          bits_left_r, bits_left_nxt;
  logic [7:0]               sh_r, sh_nxt;
  logic [POSITION_BITS-1:0] src_r, src_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     rd_pend_r, rd_pend_nxt;
  logic                     fwd_r, fwd_nxt;
  logic [7:0]               fwd_d_r, fwd_d_nxt;
  logic                     hold_v_r, hold_v_nxt;
  logic [7:0]               hold_d_r, hold_d_nxt;
  logic                     hold_eos_r, hold_eos_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_d_r, out_d_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_eos_r, out_eos_nxt;

  logic                     ram_we;
  logic [POSITION_BITS-1:0] ram_waddr;
  logic [7:0]               ram_wdata;
  logic                     ram_re;
  logic [POSITION_BITS-1:0] ram_raddr;
  logic [7:0]               ram_q;

  logic                     can_emit;
  logic                     slot_ok;
  logic                     prod;
  logic                     prod_eos;
  logic [7:0]               prod_d;
  logic                     consume;
  logic                     issue;
  logic                     bit_in;
  logic [PB_W-1:0]          pend_sh;
  logic [PC_W-1:0]          pcnt_inc;
  logic [PC_W-1:0]          need;
  logic [POSITION_BITS-1:0] pos_val;

  lzssd_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  assign can_emit = !out_valid_r || out_tready;
  assign slot_ok  = !hold_v_r || can_emit;
  assign bit_in   = sh_r[7];
  assign pend_sh  = {pend_r[PB_W-2:0], bit_in};
  assign pcnt_inc = pcnt_r + PC_W'(1);
  assign pos_val  = pend_sh[POSITION_BITS-1:0];

  always_comb begin
    case (phase_r)
      PH_LIT:  need = PC_W'(LIT_BITS);
      PH_POS:  need = PC_W'(POSITION_BITS);
      PH_LEN:  need = PC_W'(LENGTH_BITS);
      default: need = PC_W'(LIT_BITS);
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    pend_nxt      = pend_r;
    pcnt_nxt      = pcnt_r;
    mpos_nxt      = mpos_r;
    done_nxt      = done_r;
    wp_nxt        = wp_r;
    clr_nxt       = clr_r;
    bits_left_nxt = bits_left_r;
    sh_nxt        = sh_r;
    src_nxt       = src_r;
    cnt_nxt       = cnt_r;
    rd_pend_nxt   = rd_pend_r;
    fwd_nxt       = fwd_r;
    fwd_d_nxt     = fwd_d_r;
    hold_v_nxt    = hold_v_r;
    hold_d_nxt    = hold_d_r;
    hold_eos_nxt  = hold_eos_r;
    out_valid_nxt = out_valid_r;
    out_d_nxt     = out_d_r;
    out_last_nxt  = out_last_r;
    out_eos_nxt   = out_eos_r;
    ram_we        = 1'b0;
    ram_waddr     = wp_r;
    ram_wdata     = 8'd0;
    ram_re        = 1'b0;
    ram_raddr     = src_r;
    prod          = 1'b0;
    prod_eos      = 1'b0;
    prod_d        = 8'd0;
    consume       = 1'b0;
    issue         = 1'b0;
    in_tready     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + POSITION_BITS'(1);
        if (clr_r == {POSITION_BITS{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && !done_r) begin
          sh_nxt        = in_tdata;
          bits_left_nxt = BL_W'(BYTE_BITS);
          state_nxt     = S_BITS;
        end
      end
      S_BITS: begin
        if (phase_r == PH_FLAG) begin
          phase_nxt = bit_in ? PH_LIT : PH_POS;
          pend_nxt  = '0;
          pcnt_nxt  = '0;
          consume   = 1'b1;
        end else if (pcnt_inc != need) begin
          pend_nxt = pend_sh;
          pcnt_nxt = pcnt_inc;
          consume  = 1'b1;
        end else begin
          case (phase_r)
            PH_LIT: begin
              if (slot_ok) begin
                prod      = 1'b1;
                prod_d    = pend_sh[7:0];
                phase_nxt = PH_FLAG;
                pend_nxt  = '0;
                pcnt_nxt  = '0;
                consume   = 1'b1;
              end
            end
            PH_POS: begin
              if (pos_val == '0) begin
                if (slot_ok) begin
                  prod      = 1'b1;
                  prod_eos  = 1'b1;
                  done_nxt  = 1'b1;
                  phase_nxt = PH_FLAG;
                  pend_nxt  = '0;
                  pcnt_nxt  = '0;
                  state_nxt = S_FLUSH;
                end
              end else begin
                mpos_nxt  = pos_val;
                phase_nxt = PH_LEN;
                pend_nxt  = '0;
                pcnt_nxt  = '0;
                consume   = 1'b1;
              end
            end
            PH_LEN: begin
              cnt_nxt   = CNT_W'(pend_sh[LENGTH_BITS-1:0]) + CNT_W'(2);
              src_nxt   = mpos_r;
              phase_nxt = PH_FLAG;
              pend_nxt  = '0;
              pcnt_nxt  = '0;
              consume   = 1'b1;
              state_nxt = S_COPY;
            end
            default: begin
              phase_nxt = PH_FLAG;
            end
          endcase
        end
        if (consume) begin
          sh_nxt        = {sh_r[6:0], 1'b0};
          bits_left_nxt = bits_left_r - BL_W'(1);
          if (state_nxt == S_BITS && bits_left_r == BL_W'(1)) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_COPY: begin
        if (!rd_pend_r) begin
          issue = 1'b1;
        end else if (slot_ok) begin
          prod   = 1'b1;
          prod_d = fwd_r ? fwd_d_r : ram_q;
          if (cnt_r != '0) begin
            issue = 1'b1;
          end else begin
            rd_pend_nxt = 1'b0;
            state_nxt   = (bits_left_r == '0) ? S_FLUSH : S_BITS;
          end
        end
        if (issue) begin
          ram_re      = 1'b1;
          ram_raddr   = src_r;
          src_nxt     = src_r + POSITION_BITS'(1);
          cnt_nxt     = cnt_r - CNT_W'(1);
          rd_pend_nxt = 1'b1;
          fwd_nxt     = prod && (src_r == wp_r);
          fwd_d_nxt   = prod_d;
        end
      end
      S_FLUSH: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_d_nxt     = hold_d_r;
          out_last_nxt  = 1'b1;
          out_eos_nxt   = hold_eos_r;
          hold_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (prod) begin
      if (hold_v_r) begin
        out_valid_nxt = 1'b1;
        out_d_nxt     = hold_d_r;
        out_last_nxt  = 1'b0;
        out_eos_nxt   = hold_eos_r;
      end
      hold_v_nxt   = 1'b1;
      hold_d_nxt   = prod_d;
      hold_eos_nxt = prod_eos;
      if (!prod_eos) begin
        ram_we    = 1'b1;
        ram_waddr = wp_r;
        ram_wdata = prod_d;
        wp_nxt    = wp_r + POSITION_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      phase_r     <= PH_FLAG;
      pend_r      <= '0;
      pcnt_r      <= '0;
      mpos_r      <= '0;
      done_r      <= 1'b0;
      wp_r        <= POSITION_BITS'(1);
      clr_r       <= '0;
      bits_left_r <= '0;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      fwd_r       <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pend_r      <= pend_nxt;
      pcnt_r      <= pcnt_nxt;
      mpos_r      <= mpos_nxt;
      done_r      <= done_nxt;
      wp_r        <= wp_nxt;
      clr_r       <= clr_nxt;
      bits_left_r <= bits_left_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      fwd_r       <= fwd_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    src_r      <= src_nxt;
    fwd_d_r    <= fwd_d_nxt;
    hold_d_r   <= hold_d_nxt;
    hold_eos_r <= hold_eos_nxt;
    out_d_r    <= out_d_nxt;
    out_last_r <= out_last_nxt;
    out_eos_r  <= out_eos_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_d_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_eos_r;

`ifndef SYNTHESIS
  a_accept_empty_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !hold_v_r)
    else $error("input word accepted with a staged result pending");

  a_read_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == S_COPY))
    else $error("window read outstanding outside copy");

  a_eos_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_eos_r) |-> out_last_r)
    else $error("end-of-stream word without tlast");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && hold_v_r) |=> $stable(out_d_r) && $stable(hold_d_r))
    else $error("result produced while output path was full");
`endif

endmodule

// File: tb/sv/lzss_decode_checker.sv
`timescale 1ns / 1ps
// Checker for the LZSS bitstream decoder: decodes every accepted input word
// and compares each output word in order. Depends on lzssd_pkg (phase codes).
module lzss_decode_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] out_byte
  input  logic       out_tlast,  // last_of_run
  input  logic       out_tuser,  // [0] end_of_stream
  output int         mismatch_cnt,
  output int         words_owed
);
  import lzssd_pkg::*;

  localparam int POS_W   = 12;
  localparam int LEN_W   = 4;
  localparam int WIN     = 1 << POS_W;
  localparam int MAX_RUN = (1 << LEN_W) + 1;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       eos;
  } dec_word_t;

  dec_word_t        dec_words_q[$];
  dec_word_t        run_buf[MAX_RUN];
  int               run_n;
  logic [7:0]       hist[WIN];
  logic [POS_W-1:0] wr_ptr;
  logic [POS_W-1:0] match_pos;
  phase_t           phase;
  logic [15:0]      acc;
  int               acc_n;
  bit               done;
  int               err_n;
  int               word_n;
  dec_word_t        got;

  task automatic report_mismatch(input string what);
    if (err_n < 100) $display("%0t: mismatch at output word %0d: %s", $time, word_n, what);
    err_n++;
  endtask

  function automatic void emit_word(input logic [7:0] d, input logic e);
    run_buf[run_n] = '{d, 1'b0, e};
    run_n++;
  endfunction

  function automatic void put_data(input logic [7:0] d);
    hist[wr_ptr] = d;
    wr_ptr++;
    emit_word(d, 1'b0);
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic             bit_v;
    int               need;
    int               total;
    logic [POS_W-1:0] src;
    run_n = 0;
    for (int k = 7; k >= 0 && !done; k--) begin
      bit_v = b[k];
      if (phase == PH_FLAG) begin
        phase = bit_v ? PH_LIT : PH_POS;
        acc   = '0;
        acc_n = 0;
      end else begin
        acc = {acc[14:0], bit_v};
        acc_n++;
        need = (phase == PH_LIT) ? LIT_BITS : (phase == PH_POS) ? POS_W : LEN_W;
        if (acc_n >= need) begin
          case (phase)
            PH_LIT: begin
              put_data(acc[7:0]);
              phase = PH_FLAG;
            end
            PH_POS: begin
              match_pos = acc[POS_W-1:0];
              if (match_pos == '0) begin
                done = 1'b1;
                emit_word(8'h00, 1'b1);
                phase = PH_FLAG;
              end else begin
                phase = PH_LEN;
              end
            end
            default: begin
              total = int'(acc[LEN_W-1:0]) + 2;
              src   = match_pos;
              for (int j = 0; j < total; j++) begin
                put_data(hist[src]);
                src++;
              end
              phase = PH_FLAG;
            end
          endcase
          acc   = '0;
          acc_n = 0;
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN; i++) hist[i] = 8'h00;
      wr_ptr    = POS_W'(1);
      match_pos = '0;
      phase     = PH_FLAG;
      acc       = '0;
      acc_n     = 0;
      done      = 1'b0;
      word_n    = 0;
      dec_words_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata);
        for (int i = 0; i < run_n; i++) begin
          got = run_buf[i];
          got.run_end = (i == run_n - 1);
          dec_words_q.push_back(got);
        end
      end
      if (out_tvalid && out_tready) begin
        if (dec_words_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word data=%02h last=%0b eos=%0b",
                                    out_tdata, out_tlast, out_tuser));
        end else begin
          got = dec_words_q.pop_front();
          if (out_tdata !== got.data)
            report_mismatch($sformatf("data %02h, want %02h", out_tdata, got.data));
          if (out_tlast !== got.run_end)
            report_mismatch($sformatf("tlast %0b, want %0b", out_tlast, got.run_end));
          if (out_tuser !== got.eos)
            report_mismatch($sformatf("tuser %0b, want %0b", out_tuser, got.eos));
        end
        word_n++;
      end
    end
    words_owed   <= dec_words_q.size();
    mismatch_cnt <= err_n;
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the LZSS bitstream decoder: builds a token stream, drives
// it with random idling and a long output hold-off. Depends on the checker.
module tb;

  localparam int N_STAGE_MIN_BYTES = 320;
  localparam int HOLD_AT           = 40;
  localparam int HOLD_CYCLES       = 600;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;
  int         mismatch_cnt;
  int         words_owed;

  bit         bit_q[$];
  logic [7:0] stream_q[$];
  int         gen_out;
  int         n_bytes;

  lzss_bitstream_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  lzss_decode_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .mismatch_cnt(mismatch_cnt),
    .words_owed  (words_owed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic push_bits(input logic [15:0] v, input int n);
    for (int k = n - 1; k >= 0; k--) bit_q.push_back(v[k]);
  endtask

  task automatic add_literal(input logic [7:0] v);
    push_bits(16'd1, 1);
    push_bits({8'h00, v}, 8);
    gen_out++;
  endtask

  task automatic add_match(input logic [11:0] pos, input logic [3:0] len);
    push_bits(16'd0, 1);
    push_bits({4'h0, pos}, 12);
    push_bits({12'h000, len}, 4);
    gen_out += int'(len) + 2;
  endtask

  function automatic logic [11:0] next_ptr();
    return 12'(1 + gen_out);
  endfunction

  function automatic int stage_of(input int idx);
    return (idx < n_bytes / 3) ? 0 : (idx < 2 * n_bytes / 3) ? 1 : 2;
  endfunction

  // stimulus: build the whole stream, then send it
  initial begin
    int          i;
    int          r;
    int          idle_pct;
    logic [11:0] pos;
    logic [3:0]  len;
    logic [7:0]  b;
    gen_out = 0;
    add_literal(8'h00);
    add_literal(8'hFF);
    add_literal(8'h80);
    add_literal(8'h01);
    add_match(12'd1, 4'd0);
    add_match(next_ptr() - 12'd1, 4'd15);
    add_match(12'hFFF, 4'd15);
    add_match(next_ptr(), 4'd3);
    add_literal(8'h5A);
    add_match(12'd2, 4'd7);
    while (bit_q.size() < N_STAGE_MIN_BYTES * 8) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        push_bits(16'($urandom), $urandom_range(1, 7));
      end else if (r < 14) begin
        add_literal(8'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0:       pos = next_ptr() - 12'($urandom_range(1, 16));
          1:       pos = 12'hFFF - 12'($urandom_range(0, 15));
          default: pos = 12'($urandom_range(1, 4095));
        endcase
        if (pos == 12'd0) pos = 12'd1;
        len = ($urandom_range(0, 99) < 70) ? 4'd15 : 4'($urandom_range(0, 15));
        add_match(pos, len);
      end
    end
    push_bits(16'd0, 13);
    while (bit_q.size() % 8 != 0) push_bits(16'($urandom), 1);
    repeat (4) push_bits(16'($urandom), 8);
    for (i = 0; i < bit_q.size(); i += 8) begin
      for (int k = 0; k < 8; k++) b[7-k] = bit_q[i+k];
      stream_q.push_back(b);
    end
    n_bytes = stream_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (i = 0; i < n_bytes; i++) begin
      idle_pct = (stage_of(i) == 0) ? 13 : (stage_of(i) == 1) ? 57 : 0;
      while ($urandom_range(0, 99) < idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= stream_q[i];
      do @(posedge clk); while (!in_tready);
    end
    in_tvalid <= 1'b0;

    while (words_owed != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_cnt == 0 && words_owed == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // receiver: count accepted input words to follow the idling stages
  initial begin
    int in_seen;
    int hold_left;
    bit hold_done;
    int idle_pct;
    in_seen   = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (in_tvalid && in_tready) in_seen++;
      idle_pct = (stage_of(in_seen) == 0) ? 57 : (stage_of(in_seen) == 1) ? 13 : 0;
      if (!hold_done && in_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

endmodule
